// ===== design/srrp_pkg.sv =====
// Shared types and constants for the status report record parser.
// Depends on nothing; used by srrp_parser and status_report_record_parser.
package srrp_pkg;

  localparam int unsigned MaxEidLength = 65535;
  localparam int unsigned MaxSdnvBytes = 10;

  localparam logic [3:0] REC_TYPE_STATUS = 4'd1;
  localparam logic [63:0] EID_LEN_MIN    = 64'd5;
  localparam logic [63:0] EID_LEN_MAX    = 64'(MaxEidLength);

  // Parse phases double as field identifiers of the reported word.
  localparam logic [4:0] PH_HEADER  = 5'd0;
  localparam logic [4:0] PH_FLAGS   = 5'd1;
  localparam logic [4:0] PH_REASON  = 5'd2;
  localparam logic [4:0] PH_FRAGOFS = 5'd3;
  localparam logic [4:0] PH_FRAGLEN = 5'd4;
  localparam logic [4:0] PH_TIME0   = 5'd5;
  localparam logic [4:0] PH_TIMEEND = 5'd14;
  localparam logic [4:0] PH_EIDLEN  = 5'd17;
  localparam logic [4:0] PH_EIDBYTE = 5'd18;

  localparam int unsigned LenWidth = 17;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_TYPE      = 3'd1,
    ERR_SDNV_LONG = 3'd2,
    ERR_EID_LEN   = 3'd3,
    ERR_TRUNC     = 3'd4
  } err_e;

  typedef struct packed {
    logic [4:0]          fid;
    logic [63:0]         value;
    err_e                err;
    logic                done;
    logic [LenWidth-1:0] len;
  } result_t;

endpackage

// ===== design/srrp_parser.sv =====
// Record parse state and the combinational step that consumes one record byte.
// Depends on srrp_pkg for phase codes, error codes and the result struct.
module srrp_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic              eoi_i,
  output logic              have_o,
  output srrp_pkg::result_t res_o
);
  import srrp_pkg::*;

  logic [4:0]          phase_q, phase_d;
  logic [63:0]         acc_q, acc_d;
  logic [3:0]          cnt_q, cnt_d;
  logic                frag_q, frag_d;
  logic [7:0]          flags_q, flags_d;
  logic [15:0]         eid_q, eid_d;
  logic [LenWidth-1:0] cons_q, cons_d;
  logic                disc_q, disc_d;

  logic [LenWidth-1:0] cons_inc;
  logic [63:0]         acc_shift;
  logic [3:0]          cnt_inc;
  logic [15:0]         eid_left;
  logic                have;
  result_t             res;

  // First field phase after p that this record actually carries.
  function automatic logic [4:0] next_phase(input logic [4:0] p, input logic frag,
                                            input logic [7:0] flags);
    logic [4:0] r;
    logic [4:0] c;
    logic       pres;
    r = PH_EIDLEN;
    for (int i = 16; i >= 3; i--) begin
      c = 5'(i);
      if (c == PH_FRAGOFS || c == PH_FRAGLEN) begin
        pres = frag;
      end else if (c >= PH_TIME0 && c <= PH_TIMEEND) begin
        pres = flags[3'((i - 5) >> 1)];
      end else begin
        pres = 1'b1;
      end
      if (c > p && pres) begin
        r = c;
      end
    end
    return r;
  endfunction

  assign cons_inc  = cons_q + 1'b1;
  assign acc_shift = {acc_q[56:0], byte_i[6:0]};
  assign cnt_inc   = cnt_q + 1'b1;
  assign eid_left  = (eid_q != '0) ? eid_q - 1'b1 : eid_q;

  always_comb begin
    phase_d   = phase_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    frag_d    = frag_q;
    flags_d   = flags_q;
    eid_d     = eid_q;
    cons_d    = cons_q;
    disc_d    = disc_q;
    have      = 1'b0;
    res.fid   = phase_q;
    res.value = '0;
    res.err   = ERR_NONE;
    res.done  = 1'b0;
    res.len   = '0;

    if (disc_q) begin
      if (eoi_i) begin
        disc_d = 1'b0;
      end
    end else begin
      cons_d = cons_inc;
      if (phase_q == PH_HEADER) begin
        if (byte_i[7:4] != REC_TYPE_STATUS) begin
          res.err = ERR_TYPE;
        end else begin
          frag_d    = byte_i[0];
          res.value = {63'd0, byte_i[0]};
          have      = 1'b1;
          phase_d   = PH_FLAGS;
        end
      end else if (phase_q == PH_FLAGS) begin
        flags_d   = byte_i;
        res.value = {56'd0, byte_i};
        have      = 1'b1;
        phase_d   = PH_REASON;
      end else if (phase_q == PH_REASON) begin
        res.value = {56'd0, byte_i};
        have      = 1'b1;
        phase_d   = next_phase(PH_REASON, frag_q, flags_q);
      end else if (phase_q <= PH_EIDLEN) begin
        if (acc_q[63:57] != '0) begin
          res.err = ERR_SDNV_LONG;
        end else begin
          acc_d = acc_shift;
          cnt_d = cnt_inc;
          if (byte_i[7]) begin
            if (cnt_inc >= 4'(MaxSdnvBytes)) begin
              res.err = ERR_SDNV_LONG;
            end
          end else begin
            res.value = acc_shift;
            acc_d     = '0;
            cnt_d     = '0;
            if (phase_q == PH_EIDLEN) begin
              if (acc_shift < EID_LEN_MIN || acc_shift > EID_LEN_MAX) begin
                res.err = ERR_EID_LEN;
              end else begin
                eid_d   = acc_shift[15:0];
                have    = 1'b1;
                phase_d = PH_EIDBYTE;
              end
            end else begin
              have    = 1'b1;
              phase_d = next_phase(phase_q, frag_q, flags_q);
            end
          end
        end
      end else begin
        // Any phase past the EID length passes record bytes through.
        res.fid   = PH_EIDBYTE;
        res.value = {56'd0, byte_i};
        have      = 1'b1;
        eid_d     = eid_left;
        res.done  = (eid_left == '0);
      end

      if (res.err != ERR_NONE) begin
        if (res.err != ERR_EID_LEN) begin
          res.value = '0;
        end
        res.done = 1'b1;
        if (!eoi_i) begin
          disc_d = 1'b1;
        end
      end else if (res.done) begin
        res.len = cons_inc;
      end else if (eoi_i) begin
        res.err  = ERR_TRUNC;
        res.done = 1'b1;
        if (!have) begin
          res.fid   = phase_q;
          res.value = '0;
        end
      end

      if (res.done) begin
        have    = 1'b1;
        phase_d = PH_HEADER;
        acc_d   = '0;
        cnt_d   = '0;
        frag_d  = 1'b0;
        flags_d = '0;
        eid_d   = '0;
        cons_d  = '0;
      end
    end
  end

  assign have_o = have;
  assign res_o  = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      acc_q   <= '0;
      cnt_q   <= '0;
      frag_q  <= 1'b0;
      flags_q <= '0;
      eid_q   <= '0;
      cons_q  <= '0;
      disc_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      frag_q  <= frag_d;
      flags_q <= flags_d;
      eid_q   <= eid_d;
      cons_q  <= cons_d;
      disc_q  <= disc_d;
    end
  end

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PH_EIDBYTE) else $error("parse phase out of range");

  a_eid_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_EIDBYTE |-> eid_q != '0) else $error("EID phase with no bytes left");

  a_sdnv_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < 4'(MaxSdnvBytes)) else $error("SDNV byte count overran");

  a_discard_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && disc_q |-> !have) else $error("result produced while discarding");

  a_good_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && have && res.done && res.err == ERR_NONE |-> res.len >= LenWidth'(11))
    else $error("completed record shorter than the minimum");

endmodule

// ===== design/status_report_record_parser.sv =====
// Top level of the bundle status report record parser: stream ports,
// input word register and result register. Depends on srrp_pkg and srrp_parser.
//
//  Channel   Dir  tdata bits (low first)                  tuser (low first)       tlast
//  s_axis    in   [7:0] data_byte                         -                       end_of_input
//  m_axis    out  [63:0] field_value, [80:64] record_len  [4:0] field_id,         record_done
//                 [87:81] zero                            [7:5] error_code
//
// One record byte is taken per cycle while m_axis does not stall. A byte is parsed while
// it sits in the input register; any result word it yields goes into the result register.
// Parsing a byte is a single pass through one 64-bit shift/compare and the phase skip.
// Reset clears the parse state and both valid flags; the block is ready right after it.
// A stall on m_axis holds the result; s_axis keeps flowing while the result register
// can be emptied or overwritten in the same cycle.
module status_report_record_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // data_byte
  input  logic        s_axis_tlast_i,   // end_of_input
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [87:0] m_axis_tdata_o,   // field_value [63:0], record_length [80:64], zero
  output logic [7:0]  m_axis_tuser_o,   // field_id [4:0], error_code [7:5]
  output logic        m_axis_tlast_o    // record_done
);
  import srrp_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  logic       out_valid_q;
  result_t    out_res_q;

  logic       out_free;
  logic       step;
  logic       have;
  result_t    res;

  // The result register can take a new word when empty or being drained now.
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign step            = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || step;

  srrp_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .eoi_i  (in_last_q),
    .have_o (have),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (out_free) begin
        out_valid_q <= step && have;
      end
    end
  end

  // Payload registers carry no reset; the valid flags qualify them.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
    if (step && have) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_res_q.len, out_res_q.value};
  assign m_axis_tuser_o  = {out_res_q.err, out_res_q.fid};
  assign m_axis_tlast_o  = out_res_q.done;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready_i |=> out_valid_q && $stable(out_res_q))
    else $error("stalled result changed");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_free |=> in_valid_q && $stable(in_byte_q))
    else $error("pending input word lost");

  a_done_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.err != ERR_NONE |-> out_res_q.done && out_res_q.len == '0)
    else $error("error result not closing the record");

endmodule
